[rtl/assert_macros.svh]
// Assertion macros for the RTL files of the OCV interpolator; included by osti_back.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define OSTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define OSTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/osti_pkg.sv]
// Shared types, constants and OCV tables for the SOC-from-OCV interpolator.
// No dependencies; imported by every module of the block.
package osti_pkg;

  localparam int TABLE_ROWS = 20;
  localparam int TEMP_BANDS = 6;
  localparam int EDGE_COUNT = TEMP_BANDS - 1;
  localparam int ROW_W      = $clog2(TABLE_ROWS);
  localparam int BAND_W     = 3;
  localparam int MV_W       = 16;
  localparam int CK_W       = 16;
  localparam int SOC_W      = 14;
  localparam int OCV_W      = 13;

  localparam int SOC_STEP  = 500;
  localparam int SOC_FLOOR = 500;
  localparam int SOC_CEIL  = 10000;

  // quotient of the interpolation step is 0..SOC_STEP
  localparam int QUO_W = $clog2(SOC_STEP + 1);
  localparam int NUM_W = MV_W + QUO_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef logic [1:0] clamp_t;
  localparam clamp_t CLAMP_NONE = 2'd0;
  localparam clamp_t CLAMP_MIN  = 2'd1;
  localparam clamp_t CLAMP_MAX  = 2'd2;

  // Band edges moved to the raw 0.01 K scale. deg > e with deg truncated
  // toward zero becomes ck >= 27315 + 100*(e+1), minus 99 when e+1 <= 0.
  localparam logic [CK_W-1:0] NMC_CK_EDGE [EDGE_COUNT] =
    '{16'd25516, 16'd26816, 16'd27915, 16'd29115, 16'd30615};
  localparam logic [CK_W-1:0] LFP_CK_EDGE [EDGE_COUNT] =
    '{16'd26816, 16'd27915, 16'd29115, 16'd30415, 16'd31415};

  localparam logic [OCV_W-1:0] NMC_OCV [TABLE_ROWS][TEMP_BANDS] = '{
    '{13'd3435, 13'd3433, 13'd3431, 13'd3429, 13'd3424, 13'd3424},
    '{13'd3482, 13'd3480, 13'd3479, 13'd3478, 13'd3475, 13'd3474},
    '{13'd3521, 13'd3519, 13'd3518, 13'd3518, 13'd3515, 13'd3515},
    '{13'd3557, 13'd3556, 13'd3556, 13'd3556, 13'd3554, 13'd3555},
    '{13'd3586, 13'd3586, 13'd3587, 13'd3587, 13'd3586, 13'd3588},
    '{13'd3611, 13'd3612, 13'd3613, 13'd3614, 13'd3613, 13'd3616},
    '{13'd3636, 13'd3638, 13'd3639, 13'd3640, 13'd3640, 13'd3643},
    '{13'd3666, 13'd3668, 13'd3669, 13'd3671, 13'd3672, 13'd3675},
    '{13'd3708, 13'd3710, 13'd3712, 13'd3713, 13'd3714, 13'd3717},
    '{13'd3760, 13'd3762, 13'd3764, 13'd3765, 13'd3766, 13'd3769},
    '{13'd3813, 13'd3815, 13'd3816, 13'd3817, 13'd3818, 13'd3820},
    '{13'd3860, 13'd3862, 13'd3863, 13'd3864, 13'd3865, 13'd3867},
    '{13'd3905, 13'd3906, 13'd3908, 13'd3909, 13'd3909, 13'd3911},
    '{13'd3951, 13'd3953, 13'd3953, 13'd3954, 13'd3955, 13'd3957},
    '{13'd4002, 13'd4003, 13'd4003, 13'd4004, 13'd4004, 13'd4006},
    '{13'd4052, 13'd4053, 13'd4054, 13'd4054, 13'd4054, 13'd4056},
    '{13'd4088, 13'd4089, 13'd4090, 13'd4090, 13'd4090, 13'd4092},
    '{13'd4111, 13'd4112, 13'd4113, 13'd4114, 13'd4115, 13'd4116},
    '{13'd4137, 13'd4138, 13'd4139, 13'd4140, 13'd4141, 13'd4143},
    '{13'd4200, 13'd4201, 13'd4203, 13'd4204, 13'd4213, 13'd4207}
  };

  localparam logic [OCV_W-1:0] LFP_OCV [TABLE_ROWS][TEMP_BANDS] = '{
    '{13'd3210, 13'd3200, 13'd3199, 13'd3163, 13'd3147, 13'd3147},
    '{13'd3225, 13'd3210, 13'd3206, 13'd3204, 13'd3204, 13'd3204},
    '{13'd3243, 13'd3233, 13'd3232, 13'd3223, 13'd3219, 13'd3219},
    '{13'd3256, 13'd3252, 13'd3250, 13'd3245, 13'd3241, 13'd3241},
    '{13'd3265, 13'd3266, 13'd3265, 13'd3259, 13'd3257, 13'd3256},
    '{13'd3270, 13'd3274, 13'd3278, 13'd3277, 13'd3272, 13'd3272},
    '{13'd3272, 13'd3278, 13'd3283, 13'd3288, 13'd3290, 13'd3292},
    '{13'd3274, 13'd3279, 13'd3284, 13'd3289, 13'd3292, 13'd3295},
    '{13'd3275, 13'd3280, 13'd3284, 13'd3290, 13'd3293, 13'd3295},
    '{13'd3276, 13'd3280, 13'd3285, 13'd3290, 13'd3294, 13'd3296},
    '{13'd3278, 13'd3282, 13'd3286, 13'd3291, 13'd3295, 13'd3297},
    '{13'd3282, 13'd3286, 13'd3290, 13'd3294, 13'd3296, 13'd3299},
    '{13'd3288, 13'd3296, 13'd3302, 13'd3315, 13'd3308, 13'd3309},
    '{13'd3296, 13'd3311, 13'd3320, 13'd3328, 13'd3330, 13'd3330},
    '{13'd3304, 13'd3318, 13'd3324, 13'd3328, 13'd3330, 13'd3331},
    '{13'd3309, 13'd3319, 13'd3324, 13'd3329, 13'd3330, 13'd3331},
    '{13'd3311, 13'd3320, 13'd3324, 13'd3329, 13'd3331, 13'd3332},
    '{13'd3310, 13'd3319, 13'd3324, 13'd3329, 13'd3331, 13'd3332},
    '{13'd3311, 13'd3319, 13'd3324, 13'd3330, 13'd3332, 13'd3333},
    '{13'd3418, 13'd3412, 13'd3435, 13'd3445, 13'd3404, 13'd3438}
  };

  typedef struct packed {
    logic [MV_W-1:0] cell_millivolts;
    logic [CK_W-1:0] temp_centikelvin;
  } sample_t;

  typedef struct packed {
    logic [SOC_W-1:0]  soc_centipercent;
    logic [BAND_W-1:0] temp_band;
    clamp_t            clamp_status;
  } result_t;

  // classified item: soc = base + floor(SOC_STEP * diff / den)
  typedef struct packed {
    logic [SOC_W-1:0]  base;
    logic [MV_W-1:0]   diff;
    logic [MV_W-1:0]   den;
    logic [BAND_W-1:0] band;
    clamp_t            status;
  } work_t;

  function automatic logic [OCV_W-1:0] ocv_entry(input logic chem,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [BAND_W-1:0] band);
    return chem ? LFP_OCV[row][band] : NMC_OCV[row][band];
  endfunction

endpackage

[rtl/osti_front.sv]
// Front end: temperature band pick, row bracketing and span setup.
// Uses osti_pkg; feeds classified items into osti_fifo.
module osti_front import osti_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    chemistry,
  input  logic    push,
  output logic    full,
  input  sample_t sample,
  output logic    wr_valid,
  output work_t   wr_item,
  input  logic    wr_full
);

  logic stall;

  logic                s1_vld;
  logic [MV_W-1:0]     s1_mv;
  logic                s1_chem;
  logic [BAND_W-1:0]   s1_band;
  logic [BAND_W-1:0]   band_next;

  logic                s2_vld;
  logic [MV_W-1:0]     s2_mv;
  logic                s2_chem;
  logic [BAND_W-1:0]   s2_band;
  logic [ROW_W-1:0]    s2_row;
  clamp_t              s2_status;
  logic [ROW_W-1:0]    row_next;
  clamp_t              status_next;

  logic [OCV_W-1:0]    col [TABLE_ROWS];
  logic [TABLE_ROWS-2:0] brk;

  logic                s3_vld;
  work_t               s3_item;
  work_t               item_next;
  logic [ROW_W-1:0]    row_p1;
  logic [OCV_W-1:0]    lo;
  logic [OCV_W-1:0]    hi;
  logic [MV_W-1:0]     span;
  logic [SOC_W-1:0]    row_base;

  assign stall    = s3_vld && wr_full;
  assign full     = stall;
  assign wr_valid = s3_vld;
  assign wr_item  = s3_item;

  // band = number of edges the temperature reaches or lies above
  always_comb begin
    band_next = '0;
    for (int k = 0; k < EDGE_COUNT; k++) begin
      if (sample.temp_centikelvin >= (chemistry ? LFP_CK_EDGE[k] : NMC_CK_EDGE[k])) begin
        band_next = band_next + BAND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (!stall) begin
      s1_vld <= push;
    end
    if (!stall) begin
      s1_mv   <= sample.cell_millivolts;
      s1_chem <= chemistry;
      s1_band <= band_next;
    end
  end

  always_comb begin
    for (int r = 0; r < TABLE_ROWS; r++) begin
      col[r] = ocv_entry(s1_chem, ROW_W'(r), s1_band);
    end
    for (int r = 0; r < TABLE_ROWS - 1; r++) begin
      brk[r] = (MV_W'(col[r]) <= s1_mv) && (s1_mv <= MV_W'(col[r+1]));
    end
    // first bracketing pair wins
    row_next = '0;
    for (int r = TABLE_ROWS - 2; r >= 0; r--) begin
      if (brk[r]) begin
        row_next = ROW_W'(r);
      end
    end
    if (s1_mv <= MV_W'(col[0])) begin
      status_next = CLAMP_MIN;
    end else if (s1_mv >= MV_W'(col[TABLE_ROWS-1])) begin
      status_next = CLAMP_MAX;
    end else if (|brk) begin
      status_next = CLAMP_NONE;
    end else begin
      status_next = CLAMP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (!stall) begin
      s2_vld <= s1_vld;
    end
    if (!stall) begin
      s2_mv     <= s1_mv;
      s2_chem   <= s1_chem;
      s2_band   <= s1_band;
      s2_row    <= row_next;
      s2_status <= status_next;
    end
  end

  always_comb begin
    row_p1   = s2_row + ROW_W'(1);
    lo       = ocv_entry(s2_chem, s2_row, s2_band);
    hi       = ocv_entry(s2_chem, row_p1, s2_band);
    span     = MV_W'(hi) - MV_W'(lo);
    row_base = SOC_W'(SOC_W'(row_p1) * SOC_W'(SOC_STEP));

    item_next.band   = s2_band;
    item_next.status = s2_status;
    item_next.base   = row_base;
    item_next.diff   = s2_mv - MV_W'(lo);
    item_next.den    = span;
    // clamps and flat spans: zero numerator over unit span
    if (s2_status != CLAMP_NONE || span == '0) begin
      item_next.diff = '0;
      item_next.den  = MV_W'(1);
    end
    if (s2_status == CLAMP_MIN) begin
      item_next.base = SOC_W'(SOC_FLOOR);
    end else if (s2_status == CLAMP_MAX) begin
      item_next.base = SOC_W'(SOC_CEIL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (!stall) begin
      s3_vld <= s2_vld;
    end
    if (!stall) begin
      s3_item <= item_next;
    end
  end

endmodule

[rtl/osti_fifo.sv]
// Short queue of classified items between front end and divider.
// Uses osti_pkg for the item type and depth.
module osti_fifo import osti_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  work_t wr_item,
  input  logic  pop,
  output logic  empty,
  output work_t rd_item
);

  work_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (FIFO_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (FIFO_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

[rtl/osti_back.sv]
// Back end: scale, restoring divider one quotient bit per stage, final add.
// Uses osti_pkg and assert_macros.svh; drains osti_fifo.
`include "assert_macros.svh"
module osti_back import osti_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    rd_empty,
  input  work_t   rd_item,
  output logic    rd_pop,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int NSTG = QUO_W + 1;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [MV_W-1:0]   den;
    logic [QUO_W-1:0]  quo;
    logic [SOC_W-1:0]  base;
    logic [BAND_W-1:0] band;
    clamp_t            status;
  } div_stage_t;

  logic             en;
  logic             vld [NSTG];
  div_stage_t       stg [NSTG];
  div_stage_t       stg_next [NSTG];
  logic [NUM_W-1:0] dsh [NSTG];
  logic             out_vld;

  assign en     = !(out_vld && !pop);
  assign rd_pop = en && !rd_empty;
  assign empty  = !out_vld;

  always_comb begin
    stg_next[0].rem    = NUM_W'(rd_item.diff) * NUM_W'(SOC_STEP);
    stg_next[0].den    = rd_item.den;
    stg_next[0].quo    = '0;
    stg_next[0].base   = rd_item.base;
    stg_next[0].band   = rd_item.band;
    stg_next[0].status = rd_item.status;
    dsh[0]             = '0;
    // stage k settles quotient bit QUO_W-k
    for (int k = 1; k < NSTG; k++) begin
      dsh[k]      = NUM_W'(stg[k-1].den) << (QUO_W - k);
      stg_next[k] = stg[k-1];
      if (stg[k-1].rem >= dsh[k]) begin
        stg_next[k].rem            = stg[k-1].rem - dsh[k];
        stg_next[k].quo[QUO_W - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) begin
        vld[k] <= 1'b0;
      end
      out_vld <= 1'b0;
    end else if (en) begin
      vld[0] <= !rd_empty;
      for (int k = 1; k < NSTG; k++) begin
        vld[k] <= vld[k-1];
      end
      out_vld <= vld[NSTG-1];
    end
    if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        stg[k] <= stg_next[k];
      end
      result.soc_centipercent <= stg[NSTG-1].base + SOC_W'(stg[NSTG-1].quo);
      result.temp_band        <= stg[NSTG-1].band;
      result.clamp_status     <= stg[NSTG-1].status;
    end
  end

  `OSTI_ASSERT(a_den_nonzero, !rd_empty |-> (rd_item.den != '0), "zero span reached divider")
  `OSTI_ASSERT(a_soc_range,
    out_vld |-> (result.soc_centipercent >= SOC_W'(SOC_FLOOR)
                 && result.soc_centipercent <= SOC_W'(SOC_CEIL)),
    "soc out of range")
  `OSTI_ASSERT(a_clamp_min,
    (out_vld && result.clamp_status == CLAMP_MIN)
      |-> (result.soc_centipercent == SOC_W'(SOC_FLOOR)),
    "min clamp without floor soc")

endmodule

[rtl/ocv_soc_table_interpolator_top.sv]
// SOC-from-OCV interpolator: accepts one item per clock while full is low
// and the result side keeps up with pop.
// A result passes 3 front stages, the queue, scaling, a 9-stage divider
// (one quotient bit per stage) and the output register.
// Reset (rst, synchronous) empties every stage and the queue and selects NMC.
// Depends on osti_pkg, osti_front, osti_fifo, osti_back.
module ocv_soc_table_interpolator_top import osti_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  sample_t sample,
  output logic    empty,
  input  logic    pop,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data
);

  logic  chemistry;
  logic  q_push;
  logic  q_full;
  work_t q_wr_item;
  logic  q_pop;
  logic  q_empty;
  work_t q_rd_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chemistry <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      chemistry <= cfg_data;
    end
  end

  osti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chemistry (chemistry),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .wr_valid  (q_push),
    .wr_item   (q_wr_item),
    .wr_full   (q_full)
  );

  osti_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .full    (q_full),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_rd_item)
  );

  osti_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_empty (q_empty),
    .rd_item  (q_rd_item),
    .rd_pop   (q_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

[tb/sv/ocv_soc_table_interpolator_checker.sv]
// Checker for the OCV interpolator: watches the sample, result and chemistry channels,
// predicts each result from its own copy of the OCV tables and compares.
// Depends on osti_pkg for the port struct types and the clamp status codes.
module ocv_soc_table_interpolator_checker import osti_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  sample_t sample,
  input  logic    empty,
  input  logic    pop,
  input  result_t result,
  input  logic    cfg_valid,
  input  logic    cfg_ready,
  input  logic    cfg_data,
  output int      mismatches,
  output int      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS         = 20;
  localparam int BANDS        = 6;
  localparam int EDGES        = 5;
  localparam int ZERO_C_CK    = 27315;
  localparam int SOC_PER_ROW  = 500;
  localparam int SOC_MIN      = 500;
  localparam int SOC_MAX      = 10000;

  localparam int NMC_MV [ROWS][BANDS] = '{
    '{3435, 3433, 3431, 3429, 3424, 3424},
    '{3482, 3480, 3479, 3478, 3475, 3474},
    '{3521, 3519, 3518, 3518, 3515, 3515},
    '{3557, 3556, 3556, 3556, 3554, 3555},
    '{3586, 3586, 3587, 3587, 3586, 3588},
    '{3611, 3612, 3613, 3614, 3613, 3616},
    '{3636, 3638, 3639, 3640, 3640, 3643},
    '{3666, 3668, 3669, 3671, 3672, 3675},
    '{3708, 3710, 3712, 3713, 3714, 3717},
    '{3760, 3762, 3764, 3765, 3766, 3769},
    '{3813, 3815, 3816, 3817, 3818, 3820},
    '{3860, 3862, 3863, 3864, 3865, 3867},
    '{3905, 3906, 3908, 3909, 3909, 3911},
    '{3951, 3953, 3953, 3954, 3955, 3957},
    '{4002, 4003, 4003, 4004, 4004, 4006},
    '{4052, 4053, 4054, 4054, 4054, 4056},
    '{4088, 4089, 4090, 4090, 4090, 4092},
    '{4111, 4112, 4113, 4114, 4115, 4116},
    '{4137, 4138, 4139, 4140, 4141, 4143},
    '{4200, 4201, 4203, 4204, 4213, 4207}
  };

  localparam int LFP_MV [ROWS][BANDS] = '{
    '{3210, 3200, 3199, 3163, 3147, 3147},
    '{3225, 3210, 3206, 3204, 3204, 3204},
    '{3243, 3233, 3232, 3223, 3219, 3219},
    '{3256, 3252, 3250, 3245, 3241, 3241},
    '{3265, 3266, 3265, 3259, 3257, 3256},
    '{3270, 3274, 3278, 3277, 3272, 3272},
    '{3272, 3278, 3283, 3288, 3290, 3292},
    '{3274, 3279, 3284, 3289, 3292, 3295},
    '{3275, 3280, 3284, 3290, 3293, 3295},
    '{3276, 3280, 3285, 3290, 3294, 3296},
    '{3278, 3282, 3286, 3291, 3295, 3297},
    '{3282, 3286, 3290, 3294, 3296, 3299},
    '{3288, 3296, 3302, 3315, 3308, 3309},
    '{3296, 3311, 3320, 3328, 3330, 3330},
    '{3304, 3318, 3324, 3328, 3330, 3331},
    '{3309, 3319, 3324, 3329, 3330, 3331},
    '{3311, 3320, 3324, 3329, 3331, 3332},
    '{3310, 3319, 3324, 3329, 3331, 3332},
    '{3311, 3319, 3324, 3330, 3332, 3333},
    '{3418, 3412, 3435, 3445, 3404, 3438}
  };

  // inclusive upper bound in whole degrees C of every band but the hottest
  localparam int NMC_DEG_EDGE [EDGES] = '{-18, -5, 5, 17, 32};
  localparam int LFP_DEG_EDGE [EDGES] = '{-5, 5, 17, 30, 40};

  logic    lfp_sel = 1'b0;
  result_t soc_expected_q [$];
  int      errs = 0;
  int      pending_n = 0;

  assign mismatches  = errs;
  assign outstanding = pending_n;

  function automatic result_t predict_soc(input sample_t s, input logic lfp);
    int      mv;
    int      deg;
    int      band;
    int      lo;
    int      hi;
    int      soc;
    bit      found;
    int      col [ROWS];
    result_t r;
    mv  = int'(s.cell_millivolts);
    // signed int division truncates toward zero
    deg = (int'(s.temp_centikelvin) - ZERO_C_CK) / 100;
    if (deg < -128) deg = -128;
    if (deg > 127) deg = 127;
    band = 0;
    for (int k = 0; k < EDGES; k++)
      if (deg > (lfp ? LFP_DEG_EDGE[k] : NMC_DEG_EDGE[k])) band++;
    if (band > BANDS - 1) band = BANDS - 1;
    for (int i = 0; i < ROWS; i++) col[i] = lfp ? LFP_MV[i][band] : NMC_MV[i][band];
    soc = SOC_MAX;
    r.clamp_status = CLAMP_MAX;
    if (mv <= col[0]) begin
      soc = SOC_MIN;
      r.clamp_status = CLAMP_MIN;
    end else if (mv >= col[ROWS-1]) begin
      soc = SOC_MAX;
      r.clamp_status = CLAMP_MAX;
    end else begin
      found = 1'b0;
      // first bracketing pair wins; LFP columns are not monotonic
      for (int row = 0; row < ROWS - 1; row++) begin
        lo = col[row];
        hi = col[row+1];
        if (!found && lo <= mv && mv <= hi) begin
          found = 1'b1;
          soc = (row + 1) * SOC_PER_ROW;
          if (hi != lo) soc += (SOC_PER_ROW * (mv - lo)) / (hi - lo);
          r.clamp_status = CLAMP_NONE;
        end
      end
    end
    r.soc_centipercent = soc[SOC_W-1:0];
    r.temp_band        = band[BAND_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    int      bad;
    bad = 0;
    if (rst) begin
      lfp_sel = 1'b0;
      soc_expected_q.delete();
    end else begin
      if (pop && !empty) begin
        if (soc_expected_q.size() == 0) begin
          $error("result with no item waiting: soc %0d band %0d status %0d",
                 result.soc_centipercent, result.temp_band, result.clamp_status);
          bad++;
        end else begin
          want = soc_expected_q.pop_front();
          if (result.soc_centipercent !== want.soc_centipercent) begin
            $error("soc_centipercent: expected %0d, actual %0d",
                   want.soc_centipercent, result.soc_centipercent);
            bad++;
          end
          if (result.temp_band !== want.temp_band) begin
            $error("temp_band: expected %0d, actual %0d", want.temp_band, result.temp_band);
            bad++;
          end
          if (result.clamp_status !== want.clamp_status) begin
            $error("clamp_status: expected %0d, actual %0d",
                   want.clamp_status, result.clamp_status);
            bad++;
          end
        end
      end
      if (push && !full) soc_expected_q.push_back(predict_soc(sample, lfp_sel));
      if (cfg_valid && cfg_ready) lfp_sel = cfg_data;
    end
    errs      <= errs + bad;
    pending_n <= soc_expected_q.size();
  end

endmodule

[tb/sv/ocv_soc_table_interpolator_top_test.sv]
// Testbench top for the OCV interpolator: clock, reset, sample and result traffic,
// chemistry writes and the verdict. Depends on osti_pkg, the block and
// ocv_soc_table_interpolator_checker.
module ocv_soc_table_interpolator_top_test import osti_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CHEM_NMC    = 1'b0;
  localparam logic CHEM_LFP    = 1'b1;
  localparam int   STALL_LIMIT = 1000;
  localparam int   SETTLE      = 30;
  localparam int   PHASE_ITEMS = 170;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  sample_t sample = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data = 1'b0;
  int      mismatches;
  int      outstanding;

  bit      no_idle = 1'b0;
  logic    lfp_mode = CHEM_NMC;

  initial forever #5 clk = ~clk;

  ocv_soc_table_interpolator_top DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ocv_soc_table_interpolator_checker soc_check (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  function automatic int mv_entry(input logic lfp, input int row, input int col);
    return lfp ? int'(LFP_OCV[row][col]) : int'(NMC_OCV[row][col]);
  endfunction

  task automatic send_item(input int mv, input int ck);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push   <= 1'b1;
    sample <= '{cell_millivolts: mv[MV_W-1:0], temp_centikelvin: ck[CK_W-1:0]};
    do @(posedge clk); while (full);
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_chemistry(input logic chem);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= chem;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    lfp_mode = chem;
  endtask

  initial begin : stimulus
    int col;
    int kind;
    int deg;
    int mv;
    int ck;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, clamp edges, exact entries, flat spots of the LFP table
    for (int c = 0; c < 2; c++) begin
      write_chemistry(c ? CHEM_LFP : CHEM_NMC);
      col = lfp_mode ? 3 : 4;  // 25 C column
      send_item(0, 0);
      send_item(65535, 65535);
      send_item(0, 65535);
      send_item(65535, 0);
      send_item(mv_entry(lfp_mode, 0, col), 29815);
      send_item(mv_entry(lfp_mode, 0, col) + 1, 29815);
      send_item(mv_entry(lfp_mode, 19, col), 29815);
      send_item(mv_entry(lfp_mode, 19, col) - 1, 29815);
      send_item(mv_entry(lfp_mode, 9, col), 29815);
      send_item(mv_entry(lfp_mode, 9, col) + 1, 29815);
      send_item(3324, 28315);
      send_item(3330, 30815);
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_chemistry((ph % 2) ? CHEM_LFP : CHEM_NMC);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (ph == 2 && i == PHASE_ITEMS / 2) drain_results();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          mv = $urandom_range(0, 65535);
          ck = $urandom_range(0, 65535);
        end else begin
          // degrees around every band edge, with the full truncation spread
          deg = int'($urandom_range(0, 90)) - 40;
          ck  = 27315 + 100 * deg + int'($urandom_range(0, 198)) - 99;
          if (kind < 6)
            mv = mv_entry(lfp_mode, $urandom_range(0, 19), $urandom_range(0, 5))
                 + int'($urandom_range(0, 4)) - 2;
          else if (lfp_mode)
            mv = $urandom_range(3120, 3470);
          else
            mv = $urandom_range(3400, 4240);
        end
        send_item(mv, ck);
      end
    end

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : result_sink
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // any handshake or reset restarts the count
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[ocv_soc_table_interpolator_top.f]
+incdir+rtl
rtl/osti_pkg.sv
rtl/osti_front.sv
rtl/osti_fifo.sv
rtl/osti_back.sv
rtl/ocv_soc_table_interpolator_top.sv
tb/sv/ocv_soc_table_interpolator_checker.sv
tb/sv/ocv_soc_table_interpolator_top_test.sv
